[src/mpgidx_pkg.sv]
// Shared types and constants for the MPEG-2 group indexer.
// Used by mpgidx_time_unit and mpeg2_gop_start_code_indexer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mpgidx_pkg;

  localparam int OFFSET_BITS = 40;
  localparam int OUT_BITS    = 40;
  localparam int PIC_BITS    = 31;
  localparam int RATE_BITS   = 20;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [31:0] SEQ_HEADER_CODE = 32'h0000_01B3;
  localparam logic [31:0] PICTURE_CODE    = 32'h0000_0100;
  localparam logic [29:0] MS_PER_S        = 30'd1000;

  localparam logic [PIC_BITS-1:0] PIC_MAX = {PIC_BITS{1'b1}};

  localparam logic [RATE_BITS-1:0] RATE_NUM_RESET = 20'd30000;
  localparam logic [RATE_BITS-1:0] RATE_DEN_RESET = 20'd1001;

  localparam logic [CFG_IDX_BITS-1:0] REG_RATE_NUM = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATE_DEN = 1'b1;

  // Product of picture count and scaled denominator, plus rounding half.
  localparam int PROD_BITS = 61;
  localparam int DIVD_BITS = 62;
  localparam int STEP_BITS = 6;
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIVD_BITS - 1);

  typedef struct packed {
    logic                ovf;
    logic [PIC_BITS-1:0] ms;
  } time_res_t;

endpackage

`default_nettype wire

[src/mpgidx_time_unit.sv]
// Group start time unit: pictures * denominator * 1000 / numerator, rounded.
// One multiply, one add, then a shared restoring subtract/compare one bit a cycle.
// Depends on mpgidx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpgidx_time_unit (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire  [mpgidx_pkg::PIC_BITS-1:0]   base,
  input  wire  [mpgidx_pkg::RATE_BITS-1:0]  num,
  input  wire  [mpgidx_pkg::RATE_BITS-1:0]  den,
  output logic                              res_valid,
  input  wire                               res_take,
  output mpgidx_pkg::time_res_t             res
);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_MUL  = 3'd1;
  localparam logic [2:0] T_ADD  = 3'd2;
  localparam logic [2:0] T_DIV  = 3'd3;
  localparam logic [2:0] T_HOLD = 3'd4;

  logic [2:0]                          state;
  logic [mpgidx_pkg::PIC_BITS-1:0]     base_r;
  logic [mpgidx_pkg::RATE_BITS-1:0]    num_r;
  logic [29:0]                         dk;
  logic [mpgidx_pkg::PROD_BITS-1:0]    prod;
  logic [mpgidx_pkg::DIVD_BITS-1:0]    divd;
  logic [mpgidx_pkg::RATE_BITS-1:0]    rem;
  logic [mpgidx_pkg::PIC_BITS-1:0]     quo;
  logic                                hi;
  logic [mpgidx_pkg::STEP_BITS-1:0]    step;

  logic [mpgidx_pkg::RATE_BITS:0]      trial;
  logic                                qbit;
  logic [mpgidx_pkg::RATE_BITS-1:0]    rem_next;
  logic [mpgidx_pkg::PIC_BITS-1:0]     quo_next;
  logic                                hi_next;

  always_comb begin
    trial    = {rem, divd[mpgidx_pkg::DIVD_BITS-1]};
    qbit     = (trial >= {1'b0, num_r});
    rem_next = qbit ? mpgidx_pkg::RATE_BITS'(trial - {1'b0, num_r})
                    : trial[mpgidx_pkg::RATE_BITS-1:0];
    quo_next = {quo[mpgidx_pkg::PIC_BITS-2:0], qbit};
    // Any quotient bit pushed past 31 bits means the time saturates.
    hi_next  = hi | quo[mpgidx_pkg::PIC_BITS-1];
  end

  assign res_valid = (state == T_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) begin
            base_r <= base;
            num_r  <= num;
            dk     <= 30'(den) * mpgidx_pkg::MS_PER_S;
            state  <= T_MUL;
          end
        end
        T_MUL: begin
          prod  <= mpgidx_pkg::PROD_BITS'(base_r) * mpgidx_pkg::PROD_BITS'(dk);
          state <= T_ADD;
        end
        T_ADD: begin
          divd <= {1'b0, prod} + mpgidx_pkg::DIVD_BITS'(num_r >> 1);
          rem  <= '0;
          quo  <= '0;
          hi   <= 1'b0;
          step <= '0;
          if (num_r == '0) begin
            res.ovf <= 1'b1;
            res.ms  <= mpgidx_pkg::PIC_MAX;
            state   <= T_HOLD;
          end else begin
            state <= T_DIV;
          end
        end
        T_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          hi   <= hi_next;
          divd <= {divd[mpgidx_pkg::DIVD_BITS-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == mpgidx_pkg::LAST_STEP) begin
            res.ovf <= hi_next;
            res.ms  <= hi_next ? mpgidx_pkg::PIC_MAX : quo_next;
            state   <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (res_take) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/mpeg2_gop_start_code_indexer.sv]
// MPEG-2 group indexer: scans bytes for sequence header and picture start codes.
// A byte that closes no group is taken with no result, one per cycle while s_tready is high.
// A byte that closes a group (or the end beat) holds s_tready low while
// mpgidx_time_unit multiplies and divides one quotient bit a cycle (skipping the
// divide when the numerator is zero); the result beat is registered once the unit's
// result is taken, which waits while an earlier result beat still waits on m_tready.
// Synchronous active-high reset clears the stream state and sets the rate to
// 30000/1001; the end beat also clears the stream state but keeps the rate.
// Depends on mpgidx_pkg and mpgidx_time_unit.
`timescale 1ns / 1ps
`default_nettype none

module mpeg2_gop_start_code_indexer (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [7:0]                           s_tdata,   // byte_value
  input  wire                                  s_tlast,   // is_end
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // group_offset [39:0], group_length [79:40], time_ms [110:80], time_overflow [111]
  output logic [111:0]                         m_tdata,
  input  wire                                  cfg_we,
  input  wire  [mpgidx_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [mpgidx_pkg::RATE_BITS-1:0]     cfg_data
);

  logic [mpgidx_pkg::RATE_BITS-1:0]   rate_num;
  logic [mpgidx_pkg::RATE_BITS-1:0]   rate_den;
  logic [23:0]                        recent_bytes;
  logic [mpgidx_pkg::OFFSET_BITS-1:0] byte_position;
  logic [mpgidx_pkg::OFFSET_BITS-1:0] group_start;
  logic [mpgidx_pkg::PIC_BITS-1:0]    picture_total;
  logic [mpgidx_pkg::PIC_BITS-1:0]    group_picture_base;
  logic                               busy;
  logic [mpgidx_pkg::OUT_BITS-1:0]    job_offset;
  logic [mpgidx_pkg::OUT_BITS-1:0]    job_length;

  logic                               accept;
  logic [31:0]                        word;
  logic [mpgidx_pkg::OFFSET_BITS-1:0] code_start;
  logic                               code_ok;
  logic                               is_seq;
  logic                               is_pic;
  logic                               emit;
  logic [mpgidx_pkg::OFFSET_BITS-1:0] end_pos;
  logic                               out_free;
  logic                               tu_valid;
  logic                               tu_take;
  mpgidx_pkg::time_res_t              tu_res;

  assign s_tready   = !busy;
  assign accept     = s_tvalid && s_tready;
  assign word       = {recent_bytes, s_tdata};
  assign code_start = byte_position - mpgidx_pkg::OFFSET_BITS'(3);
  assign code_ok    = (byte_position >= mpgidx_pkg::OFFSET_BITS'(3));
  assign is_seq     = code_ok && (word == mpgidx_pkg::SEQ_HEADER_CODE);
  assign is_pic     = code_ok && (word == mpgidx_pkg::PICTURE_CODE);
  // A sequence header at offset zero opens the first group without closing one.
  assign emit       = accept && (s_tlast || (is_seq && (code_start != '0)));
  assign end_pos    = s_tlast ? byte_position : code_start;
  assign out_free   = !m_tvalid || m_tready;
  assign tu_take    = tu_valid && out_free;

  mpgidx_time_unit u_time (
    .clk       (clk),
    .rst       (rst),
    .start     (emit),
    .base      (group_picture_base),
    .num       (rate_num),
    .den       (rate_den),
    .res_valid (tu_valid),
    .res_take  (tu_take),
    .res       (tu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_num <= mpgidx_pkg::RATE_NUM_RESET;
      rate_den <= mpgidx_pkg::RATE_DEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mpgidx_pkg::REG_RATE_NUM: rate_num <= cfg_data;
        mpgidx_pkg::REG_RATE_DEN: rate_den <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes       <= '0;
      byte_position      <= '0;
      group_start        <= '0;
      picture_total      <= '0;
      group_picture_base <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        recent_bytes       <= '0;
        byte_position      <= '0;
        group_start        <= '0;
        picture_total      <= '0;
        group_picture_base <= '0;
      end else begin
        if (is_seq) begin
          group_start        <= code_start;
          group_picture_base <= picture_total;
        end else if (is_pic && (picture_total != mpgidx_pkg::PIC_MAX)) begin
          picture_total <= picture_total + 1'b1;
        end
        recent_bytes  <= word[23:0];
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      job_offset <= mpgidx_pkg::OUT_BITS'(group_start);
      job_length <= mpgidx_pkg::OUT_BITS'(end_pos - group_start);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        busy <= 1'b1;
      end else if (tu_take) begin
        busy <= 1'b0;
      end
      if (tu_take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tu_take) begin
      m_tdata <= {tu_res.ovf, tu_res.ms, job_length, job_offset};
    end
  end

endmodule

`default_nettype wire
